// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge, silent while reset is high.
`define ASSERT_SYNC(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Property checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// File: hw/rtl/nns_pkg.sv
// Shared types, constants and helper functions of the nearest neighbor scaler.
// No dependencies; used by every module of the block.
`default_nettype none

package nns_pkg;

  // Field and register widths
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned STEP_W     = 3;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned OUT_DATA_W = 2 * POS_W + PIX_W;

  // Size limits
  localparam logic [DIM_W-1:0] MAX_DIM   = 13'd4096;
  localparam logic [CNT_W-1:0] MAX_SCALE = 4'd8;

  // Divider: one quotient bit a cycle
  localparam int unsigned DIV_BITS  = DIM_W;
  localparam int unsigned DIV_CNT_W = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 8'd3;
  localparam logic [CFG_IDX_W-1:0] NUM_REGS       = 8'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic cfg_write;
    logic restart;
    logic div_start;
    logic load_terms;
    logic take_pixel;
    logic load_out;
    logic advance;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_busy;
    logic active;
    logic cfg_hit;
    logic at_last;
    logic slot_free;
  } status_t;

  // Sizes above the limit count as the limit
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

  // Copies per axis: ceil of the ratio, saturated
  function automatic logic [CNT_W-1:0] copies(input logic [DIM_W-1:0] q,
                                              input logic r_nz);
    logic [DIM_W:0] n;
    n = {1'b0, q} + {{DIM_W{1'b0}}, r_nz};
    return (n > {{(DIM_W+1-CNT_W){1'b0}}, MAX_SCALE}) ? MAX_SCALE : n[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/nns_div.sv
// Restoring divider, one quotient bit per cycle, for the scale ratios.
// Depends on nns_pkg.
`default_nettype none

module nns_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [nns_pkg::DIM_W-1:0] dividend,
  input  wire logic [nns_pkg::DIM_W-1:0] divisor,
  output logic                           busy,
  output logic [nns_pkg::DIM_W-1:0]      quotient,
  output logic [nns_pkg::DIM_W-1:0]      remainder
);

  logic [nns_pkg::DIV_CNT_W-1:0] count;
  logic [nns_pkg::DIM_W-1:0]     dvs;
  logic [nns_pkg::DIM_W:0]       shifted;
  logic [nns_pkg::DIM_W:0]       diff;
  logic [nns_pkg::DIM_W-1:0]     rem_next;
  logic [nns_pkg::DIM_W-1:0]     quo_next;

  // One restoring step
  always_comb begin
    shifted = {remainder, quotient[nns_pkg::DIM_W-1]};
    diff    = shifted - {1'b0, dvs};
    if (shifted >= {1'b0, dvs}) begin
      rem_next = diff[nns_pkg::DIM_W-1:0];
      quo_next = {quotient[nns_pkg::DIM_W-2:0], 1'b1};
    end else begin
      rem_next = shifted[nns_pkg::DIM_W-1:0];
      quo_next = {quotient[nns_pkg::DIM_W-2:0], 1'b0};
    end
  end

  // Control: busy and step count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= nns_pkg::DIV_CNT_W'(nns_pkg::DIV_BITS);
    end else if (busy) begin
      count <= count - nns_pkg::DIV_CNT_W'(1);
      if (count == nns_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      dvs       <= divisor;
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= quo_next;
      remainder <= rem_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/nns_dp.sv
// Datapath: size registers, ratio dividers, raster accumulators, copy
// counters and the output word register. Depends on nns_pkg and nns_div.
`default_nettype none

module nns_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire nns_pkg::cmd_t                  cmd,
  output nns_pkg::status_t                    status,
  input  wire logic [nns_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [nns_pkg::DIM_W-1:0]      cfg_data,
  input  wire logic [nns_pkg::PIX_W-1:0]      s_tdata,
  input  wire logic                           m_tready,
  output logic                                m_tvalid,
  output logic [nns_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                m_tlast,
  output logic                                m_tuser
);

  // Size registers
  logic [nns_pkg::DIM_W-1:0] src_width, src_height, dst_width, dst_height;
  logic [nns_pkg::DIM_W-1:0] sw, sh, dw, dh;

  // Ratio terms
  logic                      div_x_busy, div_y_busy;
  logic [nns_pkg::DIM_W-1:0] qx, rx, qy, ry;
  logic [nns_pkg::CNT_W-1:0] nx, ny;
  logic                      active;

  // Raster position and exact start accumulators
  logic [nns_pkg::POS_W-1:0] src_col, src_row;
  logic [nns_pkg::POS_W-1:0] col_base, col_remainder;
  logic [nns_pkg::POS_W-1:0] row_base, row_remainder;

  // Current pixel and copy counters
  logic [nns_pkg::PIX_W-1:0]  pixel;
  logic [nns_pkg::STEP_W-1:0] ox, oy;

  logic [nns_pkg::DIM_W-1:0] col_inc, row_inc;
  logic                      col_wrap, row_wrap, last_pixel;
  logic [nns_pkg::DIM_W-1:0] col_rem_sum, row_rem_sum;
  logic                      col_carry, row_carry;
  logic                      x_end, y_end, at_last;
  logic                      out_valid;

  assign sw = nns_pkg::eff_dim(src_width);
  assign sh = nns_pkg::eff_dim(src_height);
  assign dw = nns_pkg::eff_dim(dst_width);
  assign dh = nns_pkg::eff_dim(dst_height);

  // Configuration writes; reset sizes are 1x1 to 1x1
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= nns_pkg::DIM_W'(1);
      src_height <= nns_pkg::DIM_W'(1);
      dst_width  <= nns_pkg::DIM_W'(1);
      dst_height <= nns_pkg::DIM_W'(1);
    end else if (cmd.cfg_write) begin
      unique case (cfg_index)
        nns_pkg::REG_SRC_WIDTH:  src_width  <= cfg_data;
        nns_pkg::REG_SRC_HEIGHT: src_height <= cfg_data;
        nns_pkg::REG_DST_WIDTH:  dst_width  <= cfg_data;
        nns_pkg::REG_DST_HEIGHT: dst_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Ratio dividers, dst / src per axis
  nns_div u_div_x (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (dw),
    .divisor   (sw),
    .busy      (div_x_busy),
    .quotient  (qx),
    .remainder (rx)
  );

  nns_div u_div_y (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (dh),
    .divisor   (sh),
    .busy      (div_y_busy),
    .quotient  (qy),
    .remainder (ry)
  );

  // Copy counts and enable, latched once the dividers finish
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      nx     <= '0;
      ny     <= '0;
    end else if (cmd.restart) begin
      active <= 1'b0;
    end else if (cmd.load_terms) begin
      active <= (sw != '0) && (sh != '0) && (dw != '0) && (dh != '0);
      nx     <= nns_pkg::copies(qx, rx != '0);
      ny     <= nns_pkg::copies(qy, ry != '0);
    end
  end

  // Accumulator step arithmetic
  always_comb begin
    col_inc     = {1'b0, src_col} + nns_pkg::DIM_W'(1);
    row_inc     = {1'b0, src_row} + nns_pkg::DIM_W'(1);
    col_wrap    = (col_inc >= sw);
    row_wrap    = (row_inc >= sh);
    last_pixel  = (col_inc == sw) && (row_inc == sh);
    col_rem_sum = {1'b0, col_remainder} + {1'b0, rx[nns_pkg::POS_W-1:0]};
    row_rem_sum = {1'b0, row_remainder} + {1'b0, ry[nns_pkg::POS_W-1:0]};
    col_carry   = (col_rem_sum >= sw);
    row_carry   = (row_rem_sum >= sh);
  end

  // Raster position and start accumulators
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      src_col       <= '0;
      src_row       <= '0;
      col_base      <= '0;
      col_remainder <= '0;
      row_base      <= '0;
      row_remainder <= '0;
    end else if (cmd.advance) begin
      if (col_wrap) begin
        src_col       <= '0;
        col_base      <= '0;
        col_remainder <= '0;
        if (row_wrap) begin
          src_row       <= '0;
          row_base      <= '0;
          row_remainder <= '0;
        end else begin
          src_row  <= row_inc[nns_pkg::POS_W-1:0];
          row_base <= row_base + qy[nns_pkg::POS_W-1:0]
                      + {{(nns_pkg::POS_W-1){1'b0}}, row_carry};
          row_remainder <= row_carry ? nns_pkg::POS_W'(row_rem_sum - sh)
                                     : row_rem_sum[nns_pkg::POS_W-1:0];
        end
      end else begin
        src_col  <= col_inc[nns_pkg::POS_W-1:0];
        col_base <= col_base + qx[nns_pkg::POS_W-1:0]
                    + {{(nns_pkg::POS_W-1){1'b0}}, col_carry};
        col_remainder <= col_carry ? nns_pkg::POS_W'(col_rem_sum - sw)
                                   : col_rem_sum[nns_pkg::POS_W-1:0];
      end
    end
  end

  // Copy counters, columns inner
  assign x_end   = ({1'b0, ox} == nx - nns_pkg::CNT_W'(1));
  assign y_end   = ({1'b0, oy} == ny - nns_pkg::CNT_W'(1));
  assign at_last = x_end && y_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      ox <= '0;
      oy <= '0;
    end else if (cmd.take_pixel) begin
      ox <= '0;
      oy <= '0;
    end else if (cmd.load_out) begin
      if (x_end) begin
        ox <= '0;
        oy <= oy + nns_pkg::STEP_W'(1);
      end else begin
        ox <= ox + nns_pkg::STEP_W'(1);
      end
    end
  end

  // Latched source pixel
  always_ff @(posedge clk) begin
    if (cmd.take_pixel) begin
      pixel <= s_tdata;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {pixel,
                  row_base + {{(nns_pkg::POS_W-nns_pkg::STEP_W){1'b0}}, oy},
                  col_base + {{(nns_pkg::POS_W-nns_pkg::STEP_W){1'b0}}, ox}};
      m_tlast <= at_last;
      m_tuser <= at_last && last_pixel;
    end
  end

  assign m_tvalid = out_valid;

  // Status to the controller
  always_comb begin
    status.div_busy  = div_x_busy || div_y_busy;
    status.active    = active;
    status.cfg_hit   = (cfg_index < nns_pkg::NUM_REGS);
    status.at_last   = at_last;
    status.slot_free = !out_valid || m_tready;
  end

endmodule

`default_nettype wire

// File: hw/rtl/nns_ctrl.sv
// Controller: ratio computation after reset or a size change, then one
// source pixel at a time expanded into its destination words. Uses nns_pkg.
`default_nettype none

module nns_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire nns_pkg::status_t  status,
  output nns_pkg::cmd_t          cmd
);

  typedef enum logic [1:0] {
    ST_START,
    ST_DIV,
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t state, state_next;
  logic   in_accept, cfg_accept;

  // Handshakes and commands
  always_comb begin
    cfg_ready  = (state == ST_IDLE);
    cfg_accept = cfg_valid && cfg_ready;
    s_tready   = ((state == ST_IDLE) && !cfg_valid)
              || ((state == ST_EMIT) && status.at_last && status.slot_free);
    in_accept  = s_tvalid && s_tready;

    cmd.cfg_write  = cfg_accept;
    cmd.restart    = (state == ST_START);
    cmd.div_start  = (state == ST_START);
    cmd.load_terms = (state == ST_DIV) && !status.div_busy;
    cmd.take_pixel = in_accept && status.active;
    cmd.load_out   = (state == ST_EMIT) && status.slot_free;
    cmd.advance    = cmd.load_out && status.at_last;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_START: state_next = ST_DIV;
      ST_DIV: begin
        if (!status.div_busy) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cfg_accept && status.cfg_hit) state_next = ST_START;
        else if (cmd.take_pixel)          state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd.advance) state_next = cmd.take_pixel ? ST_EMIT : ST_IDLE;
      end
      default: state_next = ST_START;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_START;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/nearest_neighbor_scaler_unit.sv
// Top level of the nearest neighbor scaler: controller plus datapath.
// Depends on nns_pkg, nns_ctrl, nns_dp (and nns_div below it).
//
// Channel  Dir  Handshake            Payload
// s_*      in   s_tvalid/s_tready    s_tdata: pixel_value
// m_*      out  m_tvalid/m_tready    m_tdata: dest_x, dest_y, out_pixel;
//                                    m_tlast: run_last; m_tuser: frame_last
// cfg_*    in   cfg_valid/cfg_ready  cfg_index: register, cfg_data: value
//
// A source pixel is expanded into nx*ny destination words, one word per cycle
// while m_tready does not stall; the next pixel is taken in the cycle its
// predecessor's last word is loaded. With any size zero a pixel is taken and
// dropped. After reset and after each write to a size register the two ratio
// dividers run with s_tready low; cfg_ready is high only when idle.
// A stall on m_tready holds the output word and the expansion behind it.
`default_nettype none

module nearest_neighbor_scaler_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [nns_pkg::PIX_W-1:0]         s_tdata,   // [31:0] pixel_value
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [11:0] dest_x, [23:12] dest_y, [55:24] out_pixel
  output logic [nns_pkg::OUT_DATA_W-1:0]         m_tdata,
  output logic                                   m_tlast,   // run_last
  output logic                                   m_tuser,   // [0] frame_last
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [nns_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [nns_pkg::DIM_W-1:0]         cfg_data
);

  nns_pkg::cmd_t    cmd;
  nns_pkg::status_t status;

  nns_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  nns_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire

// File: hw/rtl/nns_check.sv
// Port-level checker for the nearest neighbor scaler, bound to the top level.
// Depends on nns_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module nns_check (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tready,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [nns_pkg::OUT_DATA_W-1:0]    m_tdata,
  input wire logic                              m_tlast,
  input wire logic                              m_tuser,
  input wire logic                              cfg_valid,
  input wire logic                              cfg_ready,
  input wire logic [nns_pkg::CFG_IDX_W-1:0]     cfg_index
);

  logic out_stall;
  logic size_write;

  // Handshake terms
  assign out_stall  = m_tvalid && !m_tready;
  assign size_write = cfg_valid && cfg_ready && (cfg_index < nns_pkg::NUM_REGS);

  // Stalled output word holds
  `ASSERT_SYNC(a_out_hold, out_stall |=> m_tvalid && $stable({m_tdata, m_tlast, m_tuser}))

  // Frame end is always a run end
  `ASSERT_SYNC(a_frame_in_run, m_tvalid && m_tuser |-> m_tlast)

  // Ratios are being recomputed right after reset
  `ASSERT_ALWAYS(a_reset_busy, rst |=> !s_tready && !cfg_ready)

  // A size write blocks pixels and further writes while dividing
  `ASSERT_SYNC(a_cfg_busy, size_write |=> !s_tready && !cfg_ready)

endmodule

bind nearest_neighbor_scaler_unit nns_check u_check (.*);

`default_nettype wire
